// ===== src/tgcs_pkg.sv =====
// Shared types, codes and helpers for the tile grid collision/sight block.
// Used by tgcs_ctrl, tgcs_dp and tile_grid_collision_sight_core.
package tgcs_pkg;

   localparam int MAX_COLS   = 32;
   localparam int MAX_ROWS   = 16;
   localparam int COL_BITS   = 5;
   localparam int ROW_BITS   = 4;
   localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
   localparam int DEPTH      = MAX_COLS * MAX_ROWS;
   localparam int TILE_SHIFT = 10;
   localparam int HALF_UNITS = 512;

   localparam logic [2:0] OP_WRITE  = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_POINT  = 3'd2;
   localparam logic [2:0] OP_CIRCLE = 3'd3;
   localparam logic [2:0] OP_SIGHT  = 3'd4;

   localparam logic [2:0] KIND_EMPTY = 3'd0;
   localparam logic [2:0] KIND_WALL  = 3'd1;
   localparam logic [2:0] KIND_WATER = 3'd2;

   localparam logic [1:0] CSR_MAP_COLS = 2'd0;
   localparam logic [1:0] CSR_MAP_ROWS = 2'd1;

   localparam logic [5:0] COLS_RESET = 6'd20;
   localparam logic [4:0] ROWS_RESET = 5'd12;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_CLEAR, DP_WRITE, DP_RD_IDX, DP_RD_PT,
      DP_CIR_INIT, DP_RD_CIR, DP_CIR_EVAL, DP_SQX, DP_SQY, DP_SUM,
      DP_SQRT_INIT, DP_SQRT_STEP, DP_DIV_INIT_X, DP_DIV_STEP,
      DP_DIV_SAVE_X, DP_DIV_SAVE_Y, DP_SMP_INIT, DP_RD_SMP, DP_SMP_EVAL, DP_FIN
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic short_seg;
      logic sqrt_last;
      logic div_last;
      logic cir_stop;
      logic smp_stop;
   } dp_status_type;

   // world coordinate to tile index, truncated toward zero
   function automatic logic signed [8:0] tile_idx(input logic signed [18:0] v);
      logic signed [18:0] a;
      a = v + (v[18] ? 19'sd1023 : 19'sd0);
      return a[18:TILE_SHIFT];
   endfunction

   function automatic logic in_map(input logic signed [8:0] c, input logic signed [8:0] r,
                                   input logic [5:0] ceff, input logic [4:0] reff);
      return !c[8] && (c[7:0] < {2'b00, ceff}) && !r[8] && (r[7:0] < {3'b000, reff});
   endfunction

endpackage

// ===== src/tile_grid_collision_sight_core.sv =====
// Top level of the tile grid collision and line-of-sight block.
// Depends on tgcs_pkg, tgcs_ctrl and tgcs_dp.
//
// Usage: a request is taken when start is high and busy is low. The req_op
// field selects write tile, read tile, point query, circle collision or
// line of sight. Writes and unused ops give no response; every other request
// gives one response, shown for one cycle with rsp_strobe high. The receiver
// cannot stall; the response is taken in the cycle it is shown.
// The csr_ channel (always ready) sets map_cols (index 0) and map_rows
// (index 1); write it only while idle.
// Read and point query read one tile and then finish; a circle test visits
// the tiles of its box, up to 25 tiles, until one collides.
// A write raises busy while the tile is stored; unused ops do not raise busy.
// Line of sight: the squared length, its integer root, two 18-step divides,
// a read and a check per sample, then a finish step; samples run from
// 0 to isqrt(len2)/512 + 1 and the walk stops at the first wall. A segment
// shorter than 16 units skips the walk. One request at a time; busy covers it.
// After reset the tile memory is cleared one entry per cycle, all 512 entries,
// with busy high; configuration writes are taken during that pass.
module tile_grid_collision_sight_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic signed [6:0]  req_tile_col,
   input  logic signed [6:0]  req_tile_row,
   input  logic [2:0]         req_tile_value,
   input  logic signed [17:0] req_first_x,
   input  logic signed [17:0] req_first_y,
   input  logic signed [17:0] req_second_x,
   input  logic signed [17:0] req_second_y,
   input  logic [10:0]        req_circle_radius,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_tile_type,
   output logic               rsp_walkable,
   output logic               rsp_in_bounds,
   output logic               rsp_collides,
   output logic               rsp_sight_clear,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [5:0]         csr_wdata
);

   tgcs_pkg::dp_cmd_type    cmd;
   tgcs_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   tgcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start && !busy),
      .req_op     (req_op),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tgcs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_op            (req_op),
      .req_tile_col      (req_tile_col),
      .req_tile_row      (req_tile_row),
      .req_tile_value    (req_tile_value),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .req_circle_radius (req_circle_radius),
      .rsp_tile_type     (rsp_tile_type),
      .rsp_walkable      (rsp_walkable),
      .rsp_in_bounds     (rsp_in_bounds),
      .rsp_collides      (rsp_collides),
      .rsp_sight_clear   (rsp_sight_clear)
   );

endmodule

// ===== src/tgcs_ctrl.sv =====
// Controller state machine for the tile grid block.
// Depends on tgcs_pkg; drives tgcs_dp through command and status.
module tgcs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0]             req_op,
   input  tgcs_pkg::dp_status_type status,
   output tgcs_pkg::dp_cmd_type   cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_WR, S_RDI, S_RDP, S_CINIT, S_CRD, S_CEVAL,
      S_SQX, S_SQY, S_SUM, S_CHK, S_SQS, S_DIX, S_DVX, S_SVX, S_DVY, S_SVY,
      S_SRD, S_SEVAL, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = tgcs_pkg::DP_NOP;
      case (state_ff)
         S_CLR: begin
            cmd = tgcs_pkg::DP_CLEAR;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd = tgcs_pkg::DP_LOAD;
               case (req_op)
                  tgcs_pkg::OP_WRITE:  state_in = S_WR;
                  tgcs_pkg::OP_READ:   state_in = S_RDI;
                  tgcs_pkg::OP_POINT:  state_in = S_RDP;
                  tgcs_pkg::OP_CIRCLE: state_in = S_CINIT;
                  tgcs_pkg::OP_SIGHT:  state_in = S_SQX;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_WR: begin
            cmd      = tgcs_pkg::DP_WRITE;
            state_in = S_IDLE;
         end
         S_RDI: begin
            cmd      = tgcs_pkg::DP_RD_IDX;
            state_in = S_FIN;
         end
         S_RDP: begin
            cmd      = tgcs_pkg::DP_RD_PT;
            state_in = S_FIN;
         end
         S_CINIT: begin
            cmd      = tgcs_pkg::DP_CIR_INIT;
            state_in = S_CRD;
         end
         S_CRD: begin
            cmd      = tgcs_pkg::DP_RD_CIR;
            state_in = S_CEVAL;
         end
         S_CEVAL: begin
            cmd      = tgcs_pkg::DP_CIR_EVAL;
            state_in = status.cir_stop ? S_FIN : S_CRD;
         end
         S_SQX: begin
            cmd      = tgcs_pkg::DP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd      = tgcs_pkg::DP_SQY;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd      = tgcs_pkg::DP_SUM;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (status.short_seg) begin
               cmd      = tgcs_pkg::DP_SMP_INIT;
               state_in = S_FIN;
            end else begin
               cmd      = tgcs_pkg::DP_SQRT_INIT;
               state_in = S_SQS;
            end
         end
         S_SQS: begin
            cmd = tgcs_pkg::DP_SQRT_STEP;
            if (status.sqrt_last) state_in = S_DIX;
         end
         S_DIX: begin
            cmd      = tgcs_pkg::DP_DIV_INIT_X;
            state_in = S_DVX;
         end
         S_DVX: begin
            cmd = tgcs_pkg::DP_DIV_STEP;
            if (status.div_last) state_in = S_SVX;
         end
         S_SVX: begin
            cmd      = tgcs_pkg::DP_DIV_SAVE_X;
            state_in = S_DVY;
         end
         S_DVY: begin
            cmd = tgcs_pkg::DP_DIV_STEP;
            if (status.div_last) state_in = S_SVY;
         end
         S_SVY: begin
            cmd      = tgcs_pkg::DP_DIV_SAVE_Y;
            state_in = S_SRD;
         end
         S_SRD: begin
            cmd      = tgcs_pkg::DP_RD_SMP;
            state_in = S_SEVAL;
         end
         S_SEVAL: begin
            cmd      = tgcs_pkg::DP_SMP_EVAL;
            state_in = status.smp_stop ? S_FIN : S_SRD;
         end
         S_FIN: begin
            cmd      = tgcs_pkg::DP_FIN;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= (state_ff == S_FIN);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

// ===== src/tgcs_dp.sv =====
// Datapath for the tile grid block: tile memory, map size registers,
// root and divide units, circle and segment walkers. Depends on tgcs_pkg.
module tgcs_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  tgcs_pkg::dp_cmd_type    cmd,
   output tgcs_pkg::dp_status_type status,
   input  logic                    csr_write,
   input  logic [1:0]              csr_index,
   input  logic [5:0]              csr_wdata,
   input  logic [2:0]              req_op,
   input  logic signed [6:0]       req_tile_col,
   input  logic signed [6:0]       req_tile_row,
   input  logic [2:0]              req_tile_value,
   input  logic signed [17:0]      req_first_x,
   input  logic signed [17:0]      req_first_y,
   input  logic signed [17:0]      req_second_x,
   input  logic signed [17:0]      req_second_y,
   input  logic [10:0]             req_circle_radius,
   output logic [2:0]              rsp_tile_type,
   output logic                    rsp_walkable,
   output logic                    rsp_in_bounds,
   output logic                    rsp_collides,
   output logic                    rsp_sight_clear
);

   logic [2:0] mem [0:tgcs_pkg::DEPTH-1];

   logic [5:0]                        map_cols_ff;
   logic [4:0]                        map_rows_ff;
   logic [tgcs_pkg::ADDR_BITS-1:0]    clr_cnt_ff;
   logic [2:0]                        op_ff, val_ff, mem_q_ff;
   logic signed [6:0]                 col_ff, row_ff;
   logic signed [17:0]                fx_ff, fy_ff;
   logic [10:0]                       rad_ff;
   logic signed [18:0]                dx_ff, dy_ff;
   logic [37:0]                       sq_ff, d2_ff;
   logic [19:0]                       rem_ff;
   logic [18:0]                       root_ff;
   logic [4:0]                        cnt_ff;
   logic [9:0]                        steps_ff, drem_ff, rstep_x_ff, rstep_y_ff, rx_ff, ry_ff;
   logic [9:0]                        i_ff;
   logic [17:0]                       dnum_ff, dquo_ff, qstep_x_ff, qstep_y_ff, qx_ff, qy_ff;
   logic signed [8:0]                 tx_ff, ty_ff, tx0_ff, tx1_ff, ty1_ff;
   logic                              inmap_ff, inb_ff, hit_ff, clear_ff;
   logic [2:0]                        rsp_tile_ff;
   logic                              rsp_walk_ff, rsp_inb_ff, rsp_col_ff, rsp_clear_ff;

   logic [5:0]                        ceff;
   logic [4:0]                        reff;
   logic signed [8:0]                 rc, rr;
   logic                              rd_en, we, store_ok;
   logic [tgcs_pkg::ADDR_BITS-1:0]    wa;
   logic [2:0]                        kind;
   logic                              blocks;
   logic signed [20:0]                cx, cy, ddx, ddy, adx, ady;
   logic [20:0]                       lim;
   logic                              cir_hit;
   logic signed [18:0]                qxs, qys, px, py;
   logic [21:0]                       rem2, trial;
   logic [10:0]                       drem2, rxs, rys;
   logic signed [18:0]                sdx, sdy;
   logic [17:0]                       adx_n, ady_n;

   assign ceff = (map_cols_ff > 6'd32) ? 6'd32 : map_cols_ff;
   assign reff = (map_rows_ff > 5'd16) ? 5'd16 : map_rows_ff;

   assign kind   = inmap_ff ? mem_q_ff : tgcs_pkg::KIND_WALL;
   assign blocks = (kind == tgcs_pkg::KIND_WALL) || (kind == tgcs_pkg::KIND_WATER);

   assign qxs = $signed({1'b0, qx_ff});
   assign qys = $signed({1'b0, qy_ff});
   assign px  = $signed({fx_ff[17], fx_ff}) + (dx_ff[18] ? -qxs : qxs);
   assign py  = $signed({fy_ff[17], fy_ff}) + (dy_ff[18] ? -qys : qys);

   always_comb begin
      rd_en = 1'b1;
      case (cmd)
         tgcs_pkg::DP_RD_IDX: begin
            rc = {{2{col_ff[6]}}, col_ff};
            rr = {{2{row_ff[6]}}, row_ff};
         end
         tgcs_pkg::DP_RD_PT: begin
            rc = tgcs_pkg::tile_idx({fx_ff[17], fx_ff});
            rr = tgcs_pkg::tile_idx({fy_ff[17], fy_ff});
         end
         tgcs_pkg::DP_RD_SMP: begin
            rc = tgcs_pkg::tile_idx(px);
            rr = tgcs_pkg::tile_idx(py);
         end
         tgcs_pkg::DP_RD_CIR: begin
            rc = tx_ff;
            rr = ty_ff;
         end
         default: begin
            rc    = tx_ff;
            rr    = ty_ff;
            rd_en = 1'b0;
         end
      endcase
   end

   // circle box overlap against the tile currently read
   assign cx  = $signed({{2{tx_ff[8]}}, tx_ff, 10'd0}) + 21'sd512;
   assign cy  = $signed({{2{ty_ff[8]}}, ty_ff, 10'd0}) + 21'sd512;
   assign ddx = $signed({{3{fx_ff[17]}}, fx_ff}) - cx;
   assign ddy = $signed({{3{fy_ff[17]}}, fy_ff}) - cy;
   assign adx = ddx[20] ? -ddx : ddx;
   assign ady = ddy[20] ? -ddy : ddy;
   assign lim = {10'd0, rad_ff} + 21'd512;
   assign cir_hit = blocks && ($unsigned(adx) < lim) && ($unsigned(ady) < lim);

   assign rem2  = {rem_ff, d2_ff[{cnt_ff, 1'b0} +: 2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign drem2 = {drem_ff, dnum_ff[17]};
   assign rxs   = {1'b0, rx_ff} + {1'b0, rstep_x_ff};
   assign rys   = {1'b0, ry_ff} + {1'b0, rstep_y_ff};

   assign sdx   = $signed({req_second_x[17], req_second_x}) - $signed({req_first_x[17], req_first_x});
   assign sdy   = $signed({req_second_y[17], req_second_y}) - $signed({req_first_y[17], req_first_y});
   assign adx_n = dx_ff[18] ? 18'(-dx_ff) : dx_ff[17:0];
   assign ady_n = dy_ff[18] ? 18'(-dy_ff) : dy_ff[17:0];

   assign store_ok = !col_ff[6] && !col_ff[5] && (row_ff[6:4] == 3'd0);
   assign we = (cmd == tgcs_pkg::DP_CLEAR) || ((cmd == tgcs_pkg::DP_WRITE) && store_ok);
   assign wa = (cmd == tgcs_pkg::DP_CLEAR) ? clr_cnt_ff : {row_ff[3:0], col_ff[4:0]};

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= (cmd == tgcs_pkg::DP_CLEAR) ? tgcs_pkg::KIND_EMPTY : val_ff;
      if (rd_en) mem_q_ff <= mem[{rr[3:0], rc[4:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cols_ff <= tgcs_pkg::COLS_RESET;
         map_rows_ff <= tgcs_pkg::ROWS_RESET;
         clr_cnt_ff  <= '0;
      end else begin
         if (csr_write && csr_index == tgcs_pkg::CSR_MAP_COLS) map_cols_ff <= csr_wdata;
         if (csr_write && csr_index == tgcs_pkg::CSR_MAP_ROWS) map_rows_ff <= csr_wdata[4:0];
         if (cmd == tgcs_pkg::DP_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) inmap_ff <= tgcs_pkg::in_map(rc, rr, ceff, reff);
      case (cmd)
         tgcs_pkg::DP_LOAD: begin
            op_ff  <= req_op;
            col_ff <= req_tile_col;
            row_ff <= req_tile_row;
            val_ff <= req_tile_value;
            fx_ff  <= req_first_x;
            fy_ff  <= req_first_y;
            rad_ff <= req_circle_radius;
            dx_ff  <= sdx;
            dy_ff  <= sdy;
         end
         tgcs_pkg::DP_RD_PT: begin
            inb_ff <= !fx_ff[17] && (fx_ff[16:10] < {1'b0, ceff}) &&
                      !fy_ff[17] && (fy_ff[16:10] < {2'b00, reff});
         end
         tgcs_pkg::DP_CIR_INIT: begin
            tx0_ff <= tgcs_pkg::tile_idx($signed({fx_ff[17], fx_ff}) - $signed({8'd0, rad_ff}));
            tx_ff  <= tgcs_pkg::tile_idx($signed({fx_ff[17], fx_ff}) - $signed({8'd0, rad_ff}));
            tx1_ff <= tgcs_pkg::tile_idx($signed({fx_ff[17], fx_ff}) + $signed({8'd0, rad_ff}));
            ty_ff  <= tgcs_pkg::tile_idx($signed({fy_ff[17], fy_ff}) - $signed({8'd0, rad_ff}));
            ty1_ff <= tgcs_pkg::tile_idx($signed({fy_ff[17], fy_ff}) + $signed({8'd0, rad_ff}));
            hit_ff <= 1'b0;
         end
         tgcs_pkg::DP_CIR_EVAL: begin
            if (cir_hit) hit_ff <= 1'b1;
            if (tx_ff == tx1_ff) begin
               tx_ff <= tx0_ff;
               ty_ff <= ty_ff + 9'sd1;
            end else begin
               tx_ff <= tx_ff + 9'sd1;
            end
         end
         tgcs_pkg::DP_SQX: sq_ff <= 38'(dx_ff * dx_ff);
         tgcs_pkg::DP_SQY: d2_ff <= 38'(dy_ff * dy_ff);
         tgcs_pkg::DP_SUM: d2_ff <= sq_ff + d2_ff;
         tgcs_pkg::DP_SQRT_INIT: begin
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= 5'd18;
         end
         tgcs_pkg::DP_SQRT_STEP: begin
            if (rem2 >= trial) begin
               rem_ff  <= 20'(rem2 - trial);
               root_ff <= {root_ff[17:0], 1'b1};
            end else begin
               rem_ff  <= rem2[19:0];
               root_ff <= {root_ff[17:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
         tgcs_pkg::DP_DIV_INIT_X: begin
            steps_ff <= root_ff[18:9] + 10'd1;
            dnum_ff  <= adx_n;
            drem_ff  <= '0;
            cnt_ff   <= 5'd17;
         end
         tgcs_pkg::DP_DIV_STEP: begin
            if (drem2 >= {1'b0, steps_ff}) begin
               drem_ff <= 10'(drem2 - {1'b0, steps_ff});
               dquo_ff <= {dquo_ff[16:0], 1'b1};
            end else begin
               drem_ff <= drem2[9:0];
               dquo_ff <= {dquo_ff[16:0], 1'b0};
            end
            dnum_ff <= {dnum_ff[16:0], 1'b0};
            cnt_ff  <= cnt_ff - 1'b1;
         end
         tgcs_pkg::DP_DIV_SAVE_X: begin
            qstep_x_ff <= dquo_ff;
            rstep_x_ff <= drem_ff;
            dnum_ff    <= ady_n;
            drem_ff    <= '0;
            cnt_ff     <= 5'd17;
         end
         tgcs_pkg::DP_DIV_SAVE_Y: begin
            qstep_y_ff <= dquo_ff;
            rstep_y_ff <= drem_ff;
            qx_ff      <= '0;
            qy_ff      <= '0;
            rx_ff      <= '0;
            ry_ff      <= '0;
            i_ff       <= '0;
            clear_ff   <= 1'b1;
         end
         tgcs_pkg::DP_SMP_INIT: clear_ff <= 1'b1;
         tgcs_pkg::DP_SMP_EVAL: begin
            if (kind == tgcs_pkg::KIND_WALL) clear_ff <= 1'b0;
            i_ff <= i_ff + 10'd1;
            if (rxs >= {1'b0, steps_ff}) begin
               rx_ff <= 10'(rxs - {1'b0, steps_ff});
               qx_ff <= qx_ff + qstep_x_ff + 18'd1;
            end else begin
               rx_ff <= rxs[9:0];
               qx_ff <= qx_ff + qstep_x_ff;
            end
            if (rys >= {1'b0, steps_ff}) begin
               ry_ff <= 10'(rys - {1'b0, steps_ff});
               qy_ff <= qy_ff + qstep_y_ff + 18'd1;
            end else begin
               ry_ff <= rys[9:0];
               qy_ff <= qy_ff + qstep_y_ff;
            end
         end
         tgcs_pkg::DP_FIN: begin
            rsp_tile_ff  <= '0;
            rsp_walk_ff  <= 1'b0;
            rsp_inb_ff   <= 1'b0;
            rsp_col_ff   <= 1'b0;
            rsp_clear_ff <= 1'b0;
            case (op_ff)
               tgcs_pkg::OP_READ: begin
                  rsp_tile_ff <= kind;
                  rsp_walk_ff <= !blocks;
                  rsp_inb_ff  <= inmap_ff;
               end
               tgcs_pkg::OP_POINT: begin
                  rsp_tile_ff <= kind;
                  rsp_walk_ff <= !blocks;
                  rsp_inb_ff  <= inb_ff;
               end
               tgcs_pkg::OP_CIRCLE: rsp_col_ff   <= hit_ff;
               tgcs_pkg::OP_SIGHT:  rsp_clear_ff <= clear_ff;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      status.clr_last  = &clr_cnt_ff;
      status.short_seg = (d2_ff[37:8] == 30'd0);
      status.sqrt_last = (cnt_ff == 5'd0);
      status.div_last  = (cnt_ff == 5'd0);
      status.cir_stop  = cir_hit || ((tx_ff == tx1_ff) && (ty_ff == ty1_ff));
      status.smp_stop  = (kind == tgcs_pkg::KIND_WALL) || (i_ff == steps_ff);
   end

   assign rsp_tile_type   = rsp_tile_ff;
   assign rsp_walkable    = rsp_walk_ff;
   assign rsp_in_bounds   = rsp_inb_ff;
   assign rsp_collides    = rsp_col_ff;
   assign rsp_sight_clear = rsp_clear_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for tile_grid_collision_sight_core: tile writes and reads,
// point queries, circle collision and line of sight, checked against an
// in-bench predictor. Depends on tgcs_pkg and the RTL under src.
`timescale 1ns / 100ps

module testbench;

   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;
   localparam longint     TILE_UNITS   = 1024;
   localparam longint     CYCLE_LIMIT  = 20000000;

   typedef struct {
      logic [2:0] tile_type;
      logic       walkable;
      logic       in_bounds;
      logic       collides;
      logic       sight_clear;
   } rsp_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_op;
   logic signed [6:0]  req_tile_col;
   logic signed [6:0]  req_tile_row;
   logic [2:0]         req_tile_value;
   logic signed [17:0] req_first_x;
   logic signed [17:0] req_first_y;
   logic signed [17:0] req_second_x;
   logic signed [17:0] req_second_y;
   logic [10:0]        req_circle_radius;
   logic               rsp_strobe;
   logic [2:0]         rsp_tile_type;
   logic               rsp_walkable;
   logic               rsp_in_bounds;
   logic               rsp_collides;
   logic               rsp_sight_clear;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [5:0]         csr_wdata;

   logic [2:0] grid_model [tgcs_pkg::DEPTH];
   logic [5:0] cols_cfg;
   logic [4:0] rows_cfg;
   rsp_type    pending_rsp [$];
   int         errors = 0;
   int         idle_pct = 0;
   longint     cycles = 0;

   tile_grid_collision_sight_core u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic longint cols_eff();
      return (cols_cfg > tgcs_pkg::MAX_COLS) ? tgcs_pkg::MAX_COLS : longint'(cols_cfg);
   endfunction

   function automatic longint rows_eff();
      return (rows_cfg > tgcs_pkg::MAX_ROWS) ? tgcs_pkg::MAX_ROWS : longint'(rows_cfg);
   endfunction

   function automatic bit idx_in_map(longint c, longint r);
      return c >= 0 && c < cols_eff() && r >= 0 && r < rows_eff();
   endfunction

   function automatic logic [2:0] grid_read(longint c, longint r);
      if (!idx_in_map(c, r)) return tgcs_pkg::KIND_WALL;
      return grid_model[r * tgcs_pkg::MAX_COLS + c];
   endfunction

   function automatic logic [2:0] grid_at(longint x, longint y);
      return grid_read(x / TILE_UNITS, y / TILE_UNITS);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic bit blocked_kind(logic [2:0] k);
      return k == tgcs_pkg::KIND_WALL || k == tgcs_pkg::KIND_WATER;
   endfunction

   function automatic bit circle_hits(longint x, longint y, longint r);
      longint tx, ty, cx, cy, dxa, dya;
      for (ty = (y - r) / TILE_UNITS; ty <= (y + r) / TILE_UNITS; ty++) begin
         for (tx = (x - r) / TILE_UNITS; tx <= (x + r) / TILE_UNITS; tx++) begin
            if (blocked_kind(grid_read(tx, ty))) begin
               cx = tx * TILE_UNITS + tgcs_pkg::HALF_UNITS;
               cy = ty * TILE_UNITS + tgcs_pkg::HALF_UNITS;
               dxa = (x > cx) ? x - cx : cx - x;
               dya = (y > cy) ? y - cy : cy - y;
               if (dxa < tgcs_pkg::HALF_UNITS + r && dya < tgcs_pkg::HALF_UNITS + r)
                  return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit sight_free(longint x1, longint y1, longint x2, longint y2);
      longint dx, dy, steps, i;
      longint unsigned d2;
      dx = x2 - x1;
      dy = y2 - y1;
      d2 = dx * dx + dy * dy;
      if (d2 < 256) return 1'b1;
      steps = longint'(int_sqrt(d2) / tgcs_pkg::HALF_UNITS) + 1;
      for (i = 0; i <= steps; i++) begin
         if (grid_at(x1 + (dx * i) / steps, y1 + (dy * i) / steps) == tgcs_pkg::KIND_WALL)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // updates the grid model and queues the expected response, if any
   task automatic apply_request(logic [2:0] op, longint c, longint r, logic [2:0] v,
                                longint fx, longint fy, longint sx, longint sy,
                                longint rad);
      rsp_type e;
      e = '{default: '0};
      case (op)
         tgcs_pkg::OP_WRITE: begin
            if (c >= 0 && c < tgcs_pkg::MAX_COLS && r >= 0 && r < tgcs_pkg::MAX_ROWS)
               grid_model[r * tgcs_pkg::MAX_COLS + c] = v;
            return;
         end
         tgcs_pkg::OP_READ: begin
            e.tile_type = grid_read(c, r);
            e.walkable  = !blocked_kind(e.tile_type);
            e.in_bounds = idx_in_map(c, r);
         end
         tgcs_pkg::OP_POINT: begin
            e.tile_type = grid_at(fx, fy);
            e.walkable  = !blocked_kind(e.tile_type);
            e.in_bounds = fx >= 0 && fx < cols_eff() * TILE_UNITS &&
                          fy >= 0 && fy < rows_eff() * TILE_UNITS;
         end
         tgcs_pkg::OP_CIRCLE: e.collides = circle_hits(fx, fy, rad);
         tgcs_pkg::OP_SIGHT:  e.sight_clear = sight_free(fx, fy, sx, sy);
         default:   return;
      endcase
      pending_rsp.push_back(e);
   endtask

   // ---------------- response check ----------------
   task automatic check_field(string name, logic [2:0] exp_v, logic [2:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected none, actual %0d/%b%b%b%b",
                     $time, rsp_tile_type, rsp_walkable, rsp_in_bounds, rsp_collides,
                     rsp_sight_clear);
         end else begin
            e = pending_rsp.pop_front();
            check_field("tile_type", e.tile_type, rsp_tile_type);
            check_field("walkable", e.walkable, rsp_walkable);
            check_field("in_bounds", e.in_bounds, rsp_in_bounds);
            check_field("collides", e.collides, rsp_collides);
            check_field("sight_clear", e.sight_clear, rsp_sight_clear);
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic send_req(logic [2:0] op, int c, int r, int v, int fx, int fy,
                           int sx, int sy, int rad);
      int gap;
      start             <= 1'b1;
      req_op            <= op;
      req_tile_col      <= c[6:0];
      req_tile_row      <= r[6:0];
      req_tile_value    <= v[2:0];
      req_first_x       <= fx[17:0];
      req_first_y       <= fy[17:0];
      req_second_x      <= sx[17:0];
      req_second_y      <= sy[17:0];
      req_circle_radius <= rad[10:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_request(op, longint'($signed(c[6:0])), longint'($signed(r[6:0])), v[2:0],
                    longint'($signed(fx[17:0])), longint'($signed(fy[17:0])),
                    longint'($signed(sx[17:0])), longint'($signed(sy[17:0])),
                    longint'(rad[10:0]));
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 60) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [5:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == tgcs_pkg::CSR_MAP_COLS) cols_cfg = data;
      else if (idx == tgcs_pkg::CSR_MAP_ROWS) rows_cfg = data[4:0];
   endtask

   task automatic set_map(int c, int r);
      wait_idle();
      write_csr(tgcs_pkg::CSR_MAP_COLS, c[5:0]);
      write_csr(tgcs_pkg::CSR_MAP_ROWS, r[5:0]);
   endtask

   function automatic int rand_coord(int span);
      if ($urandom_range(9) == 0) return $urandom;
      return $urandom_range(span + 4096) - 2048;
   endfunction

   function automatic int rand_index();
      if ($urandom_range(7) == 0) return $urandom;
      return $urandom_range(35) - 2;
   endfunction

   // ---------------- tests ----------------
   task automatic test_reset_state();
      send_req(tgcs_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, 19, 11, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, 20, 11, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 20479, 12287, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 20480, 0, 0, 0, 0);
   endtask

   task automatic test_directed();
      send_req(tgcs_pkg::OP_WRITE, 0, 0, 7, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_WRITE, 31, 15, 1, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_WRITE, 5, 5, 1, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_WRITE, 6, 5, 2, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_WRITE, -1, 0, 1, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_WRITE, 32, 16, 1, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_WRITE, -64, 63, 1, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, 31, 15, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, -64, -1, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, 63, 63, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, -1, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, -1023, 100, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, -131072, 131071, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 5 * 1024 + 3, 5 * 1024 + 1023, 0, 0, 0);
      send_req(tgcs_pkg::OP_CIRCLE, 0, 0, 0, 4 * 1024 + 511, 5 * 1024 + 512, 0, 0, 0);
      send_req(tgcs_pkg::OP_CIRCLE, 0, 0, 0, 4 * 1024 + 511, 5 * 1024 + 512, 0, 0, 1);
      send_req(tgcs_pkg::OP_CIRCLE, 0, 0, 0, 10240, 3000, 0, 0, 2047);
      send_req(tgcs_pkg::OP_CIRCLE, 0, 0, 0, -131072, -131072, 0, 0, 2047);
      send_req(tgcs_pkg::OP_SIGHT, 0, 0, 0, 100, 100, 115, 100, 0);
      send_req(tgcs_pkg::OP_SIGHT, 0, 0, 0, 100, 100, 100, 116, 0);
      send_req(tgcs_pkg::OP_SIGHT, 0, 0, 0, 512, 5 * 1024 + 512, 9000, 5 * 1024 + 512, 0);
      send_req(tgcs_pkg::OP_SIGHT, 0, 0, 0, 512, 512, 19000, 11000, 0);
      send_req(tgcs_pkg::OP_SIGHT, 0, 0, 0, -131072, -131072, 131071, 131071, 0);
      send_req(OP_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0);
      send_req(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_map_sizes();
      set_map(0, 0);
      send_req(tgcs_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_CIRCLE, 0, 0, 0, 600, 600, 0, 0, 5);
      send_req(tgcs_pkg::OP_SIGHT, 0, 0, 0, 0, 0, 300, 0, 0);
      set_map(63, 31);
      write_csr(CSR_SPARE_LO, 6'd1);
      write_csr(CSR_SPARE_HI, 6'd63);
      send_req(tgcs_pkg::OP_READ, 31, 15, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 32767, 16383, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 32768, 16384, 0, 0, 0);
      set_map(1, 1);
      send_req(tgcs_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0);
      send_req(tgcs_pkg::OP_POINT, 0, 0, 0, 1023, 1023, 0, 0, 0);
      send_req(tgcs_pkg::OP_CIRCLE, 0, 0, 0, 512, 512, 0, 0, 600);
   endtask

   task automatic test_random(int count, int pct, int cols, int rows);
      int op_pick, fx, fy, span;
      set_map(cols, rows);
      idle_pct = pct;
      span = 33 * 1024;
      repeat (count) begin
         op_pick = $urandom_range(99);
         fx = rand_coord(span);
         fy = rand_coord(span / 2);
         if (op_pick < 22)
            send_req(tgcs_pkg::OP_WRITE, rand_index(), rand_index(), $urandom_range(7),
                     $urandom, $urandom, $urandom, $urandom, $urandom);
         else if (op_pick < 36)
            send_req(tgcs_pkg::OP_READ, rand_index(), rand_index(), $urandom_range(7),
                     $urandom, $urandom, $urandom, $urandom, $urandom);
         else if (op_pick < 54)
            send_req(tgcs_pkg::OP_POINT, $urandom, $urandom, $urandom_range(7), fx, fy,
                     $urandom, $urandom, $urandom);
         else if (op_pick < 74)
            send_req(tgcs_pkg::OP_CIRCLE, $urandom, $urandom, $urandom_range(7), fx, fy,
                     $urandom, $urandom,
                     ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(700));
         else if (op_pick < 96)
            send_req(tgcs_pkg::OP_SIGHT, $urandom, $urandom, $urandom_range(7), fx, fy,
                     ($urandom_range(15) == 0) ? $urandom : fx + $urandom_range(16000) - 8000,
                     ($urandom_range(15) == 0) ? $urandom : fy + $urandom_range(16000) - 8000,
                     $urandom);
         else
            send_req($urandom_range(OP_SPARE_HI, OP_SPARE_LO), $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_op            <= tgcs_pkg::OP_READ;
      req_tile_col      <= '0;
      req_tile_row      <= '0;
      req_tile_value    <= '0;
      req_first_x       <= '0;
      req_first_y       <= '0;
      req_second_x      <= '0;
      req_second_y      <= '0;
      req_circle_radius <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= tgcs_pkg::CSR_MAP_COLS;
      csr_wdata         <= '0;
      for (int i = 0; i < tgcs_pkg::DEPTH; i++) grid_model[i] = tgcs_pkg::KIND_EMPTY;
      cols_cfg = tgcs_pkg::COLS_RESET;
      rows_cfg = tgcs_pkg::ROWS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed();
      test_map_sizes();
      test_random(500, 25, 20, 12);
      test_random(500, 84, 32, 16);
      test_random(500, 0, 63, 31);
      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
